@@ hw/rtl/line_rasterizer_top_assert.svh @@
// Assertion macros for the RTL of the line rasteriser.
`ifndef LINE_RASTERIZER_TOP_ASSERT_SVH
`define LINE_RASTERIZER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

    localparam int PIX_W = 6;
    localparam int COL_W = 8;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [COL_W-1:0] t_col;

    typedef struct packed {
        logic steep;
        logic major_dec;
        logic minor_dec;
    } t_mode;

endpackage

`default_nettype wire

@@ hw/rtl/line_rasterizer_top.sv @@
// Channel   | Handshake                    | Beat contents
// ----------+------------------------------+---------------------------------------------
// command   | i_in_valid / o_in_ready      | start and end points, line colour
// pixel     | o_out_valid / i_out_ready    | pixel position, colour, last-pixel flag
//
// A command is taken while the sequencer is idle, then the error-term adder
// produces one pixel per cycle while the sink does not stall, so a line of
// major length L gives L + 1 pixels. A stall on the pixel channel holds the
// sequencer for as long as it lasts. Reset is synchronous and active low; it
// empties the pixel register and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none

`include "line_rasterizer_top_assert.svh"

module line_rasterizer_top
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_pix i_start_x,
    input  wire t_pix i_start_y,
    input  wire t_pix i_end_x,
    input  wire t_pix i_end_y,
    input  wire t_col i_colour_red,
    input  wire t_col i_colour_green,
    input  wire t_col i_colour_blue,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_pix      o_pixel_x,
    output t_pix      o_pixel_y,
    output t_col      o_pixel_red,
    output t_col      o_pixel_green,
    output t_col      o_pixel_blue,
    output logic      o_last_pixel
);

    localparam int C = COORD_BITS;
    localparam int E = C + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic           r_state, n_state;
    logic [C-1:0]   r_major, n_major;
    logic [C-1:0]   r_minor, n_minor;
    logic [E-1:0]   r_err, n_err;
    logic [E-1:0]   r_two_len, n_two_len;
    logic [E-1:0]   r_two_dn, n_two_dn;
    logic [E-1:0]   r_steps, n_steps;
    t_mode          r_mode, n_mode;
    t_col           r_red, r_green, r_blue;
    logic           r_out_valid, n_out_valid;
    t_pix           r_px, r_py;
    logic           r_last;
    t_col           r_ored, r_ogreen, r_oblue;

    logic [C-1:0]   x1, y1, x2, y2;
    logic [C-1:0]   arun, arise;
    logic           steep;
    logic [C-1:0]   len, adn;
    logic           accept, advance, last_now;
    logic [E:0]     sum;
    logic [E:0]     sub;
    t_pix           cur_x, cur_y;

    assign x1 = i_start_x[C-1:0];
    assign y1 = i_start_y[C-1:0];
    assign x2 = i_end_x[C-1:0];
    assign y2 = i_end_y[C-1:0];
    assign arun  = (x2 >= x1) ? (x2 - x1) : (x1 - x2);
    assign arise = (y2 >= y1) ? (y2 - y1) : (y1 - y2);
    assign steep = (x1 == x2) || (arise > arun);
    assign len   = steep ? arise : arun;
    assign adn   = steep ? arun : arise;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign advance    = (r_state == S_RUN) && (!r_out_valid || i_out_ready);
    assign last_now   = (r_steps == '0);

    // The error-term adder: it adds the minor step when the minor axis rises and
    // adds twice the length less the step when it falls, with the wrap value chosen by the compare.
    assign sum = {1'b0, r_err} + (r_mode.minor_dec
                 ? ({1'b0, r_two_len} - {1'b0, r_two_dn})
                 : {1'b0, r_two_dn});
    assign sub = sum - {1'b0, r_two_len};

    assign cur_x = r_mode.steep ? t_pix'(r_minor) : t_pix'(r_major);
    assign cur_y = r_mode.steep ? t_pix'(r_major) : t_pix'(r_minor);

    always_comb begin
        n_state     = r_state;
        n_major     = r_major;
        n_minor     = r_minor;
        n_err       = r_err;
        n_two_len   = r_two_len;
        n_two_dn    = r_two_dn;
        n_steps     = r_steps;
        n_mode      = r_mode;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (accept) begin
            n_state         = S_RUN;
            n_major         = steep ? y1 : x1;
            n_minor         = steep ? x1 : y1;
            n_err           = {1'b0, len};
            n_two_len       = {len, 1'b0};
            n_two_dn        = {adn, 1'b0};
            n_steps         = {1'b0, len};
            n_mode.steep    = steep;
            n_mode.major_dec = steep ? (y2 < y1) : (x2 < x1);
            n_mode.minor_dec = steep ? (x2 < x1) : (y2 < y1);
        end else if (advance) begin
            n_out_valid = 1'b1;
            if (last_now) begin
                n_state = S_IDLE;
            end else begin
                n_steps = r_steps - 1'b1;
                n_major = r_mode.major_dec ? (r_major - 1'b1) : (r_major + 1'b1);
                if (r_mode.minor_dec) begin
                    if (r_err >= r_two_dn) begin
                        n_err = r_err - r_two_dn;
                    end else begin
                        n_err   = sum[E-1:0];
                        n_minor = r_minor - 1'b1;
                    end
                end else begin
                    if (sum >= {1'b0, r_two_len}) begin
                        n_err   = sub[E-1:0];
                        n_minor = r_minor + 1'b1;
                    end else begin
                        n_err = sum[E-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
            r_mode      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_steps     <= n_steps;
            r_mode      <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_major   <= n_major;
        r_minor   <= n_minor;
        r_err     <= n_err;
        r_two_len <= n_two_len;
        r_two_dn  <= n_two_dn;
        if (accept) begin
            r_red   <= i_colour_red;
            r_green <= i_colour_green;
            r_blue  <= i_colour_blue;
        end
        if (advance) begin
            r_px     <= cur_x;
            r_py     <= cur_y;
            r_last   <= last_now;
            r_ored   <= r_red;
            r_ogreen <= r_green;
            r_oblue  <= r_blue;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_red   = r_ored;
    assign o_pixel_green = r_ogreen;
    assign o_pixel_blue  = r_oblue;
    assign o_last_pixel  = r_last;

    `LR_ASSERT_SAME(a_err_bound, i_clk, i_rst_n, (r_state == S_RUN) && (r_two_len != '0), r_err < r_two_len, "error term out of range")
    `LR_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, advance && last_now, (r_state == S_IDLE) && o_out_valid && o_last_pixel, "last pixel did not end the line")
    `LR_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, advance && !last_now, (r_steps == $past(r_steps) - 1'b1) && !o_last_pixel, "pixel count did not step")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import lr_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_LINES = 340;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int MAX_PRINTED = 20;

    typedef struct {
        t_pix start_x;
        t_pix start_y;
        t_pix end_x;
        t_pix end_y;
        t_col red;
        t_col green;
        t_col blue;
        bit   drain_first;
    } line_cmd_t;

    typedef struct {
        t_pix x;
        t_pix y;
        t_col red;
        t_col green;
        t_col blue;
        logic last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_pix drv_start_x = '0;
    t_pix drv_start_y = '0;
    t_pix drv_end_x = '0;
    t_pix drv_end_y = '0;
    t_col drv_red = '0;
    t_col drv_green = '0;
    t_col drv_blue = '0;

    logic in_ready;
    logic out_valid;
    t_pix pix_x;
    t_pix pix_y;
    t_col pix_red;
    t_col pix_green;
    t_col pix_blue;
    logic pix_last;

    line_cmd_t line_cmds[$];
    pixel_t    pending_pixels[$];

    int error_count = 0;
    int lines_taken = 0;
    int pixels_seen = 0;
    int sink_holds = 0;
    int drain_pauses = 0;
    int cycle_count = 0;

    line_rasterizer_top u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_start_x      (drv_start_x),
        .i_start_y      (drv_start_y),
        .i_end_x        (drv_end_x),
        .i_end_y        (drv_end_y),
        .i_colour_red   (drv_red),
        .i_colour_green (drv_green),
        .i_colour_blue  (drv_blue),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_pixel_x      (pix_x),
        .o_pixel_y      (pix_y),
        .o_pixel_red    (pix_red),
        .o_pixel_green  (pix_green),
        .o_pixel_blue   (pix_blue),
        .o_last_pixel   (pix_last)
    );

    always #4 clk = ~clk;

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_error($sformatf("pixel %0d %s got %0d expected %0d",
                pixels_seen, name, got, want));
        end
    endtask

    // Works out every pixel of one line and queues them in drawing order.
    function automatic void plot_line(input line_cmd_t c);
        int x1, y1, x2, y2, run, rise, arun, arise;
        int m0, n0, dn, len, k, major, minor, num, den, q;
        t_mode mode;
        pixel_t p;
        x1 = c.start_x;
        y1 = c.start_y;
        x2 = c.end_x;
        y2 = c.end_y;
        run = x2 - x1;
        rise = y2 - y1;
        arun = (run < 0) ? -run : run;
        arise = (rise < 0) ? -rise : rise;
        mode.steep = (x1 == x2) || (arise > arun);
        if (mode.steep) begin
            m0 = y1;
            n0 = x1;
            dn = run;
            len = arise;
            mode.major_dec = (y2 < y1);
        end else begin
            m0 = x1;
            n0 = y1;
            dn = rise;
            len = arun;
            mode.major_dec = (x2 < x1);
        end
        mode.minor_dec = (dn < 0);
        for (k = 0; k <= len; k++) begin
            major = mode.major_dec ? m0 - k : m0 + k;
            minor = n0;
            if (len > 0) begin
                // The minor offset is dn*k/len plus one half, rounded down.
                num = 2 * dn * k + len;
                den = 2 * len;
                q = num / den;
                if (num < 0 && (num % den) != 0) begin
                    q = q - 1;
                end
                minor = n0 + q;
            end
            p.x = mode.steep ? t_pix'(minor) : t_pix'(major);
            p.y = mode.steep ? t_pix'(major) : t_pix'(minor);
            p.red = c.red;
            p.green = c.green;
            p.blue = c.blue;
            p.last = (k == len);
            pending_pixels.push_back(p);
        end
    endfunction

    function automatic int pick_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                            input int r, input int g, input int b, input bit drain);
        line_cmd_t c;
        c.start_x = t_pix'(sx);
        c.start_y = t_pix'(sy);
        c.end_x = t_pix'(ex);
        c.end_y = t_pix'(ey);
        c.red = t_col'(r);
        c.green = t_col'(g);
        c.blue = t_col'(b);
        c.drain_first = drain;
        line_cmds.push_back(c);
    endtask

    function automatic int clamp_coord(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > 63) begin
            return 63;
        end
        return v;
    endfunction

    // Command driver.
    line_cmd_t drv_cmd;
    int drv_gap = 0;
    int drv_calm = 0;

    always @(posedge clk) begin
        logic next_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            next_valid = in_valid;
            if (in_valid && in_ready) begin
                plot_line(drv_cmd);
                lines_taken++;
                next_valid = 1'b0;
                drv_gap = pick_gap(drv_calm);
            end
            if (!next_valid) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (line_cmds.size() != 0 &&
                             !(line_cmds[0].drain_first && pending_pixels.size() != 0)) begin
                    drv_cmd = line_cmds.pop_front();
                    if (drv_cmd.drain_first) begin
                        drain_pauses++;
                    end
                    drv_start_x <= drv_cmd.start_x;
                    drv_start_y <= drv_cmd.start_y;
                    drv_end_x <= drv_cmd.end_x;
                    drv_end_y <= drv_cmd.end_y;
                    drv_red <= drv_cmd.red;
                    drv_green <= drv_cmd.green;
                    drv_blue <= drv_cmd.blue;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // Pixel monitor and sink.
    int sink_gap = 0;
    int sink_calm = 0;
    int hold_left = 0;
    int hold_mark = 30;

    always @(posedge clk) begin
        logic next_ready;
        pixel_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            next_ready = out_ready;
            if (out_valid && out_ready) begin
                if (pending_pixels.size() == 0) begin
                    report_error($sformatf("unexpected pixel at (%0d,%0d)", pix_x, pix_y));
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("x", pix_x, want.x);
                    check_field("y", pix_y, want.y);
                    check_field("red", pix_red, want.red);
                    check_field("green", pix_green, want.green);
                    check_field("blue", pix_blue, want.blue);
                    check_field("last", pix_last, want.last);
                end
                pixels_seen++;
                sink_gap = pick_gap(sink_calm);
                if (sink_gap > 0) begin
                    next_ready = 1'b0;
                end
            end
            // A long hold on the sink lets the rasteriser fill up and stall its command beat.
            if (hold_left == 0 && lines_taken >= hold_mark) begin
                hold_left = SINK_HOLD_CYCLES;
                sink_holds++;
                hold_mark = (hold_mark < 200) ? 200 : 32'h7fff_ffff;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (!next_ready) begin
                if (sink_gap > 0) begin
                    sink_gap--;
                end else begin
                    next_ready = 1'b1;
                end
            end
            out_ready <= next_ready;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[line_rasterizer_top] ERROR");
            $finish;
        end
    end

    initial begin
        int sx, sy, ex, ey, kind, i;
        add_line(10, 10, 10, 10, 8'h00, 8'h00, 8'h00, 1'b0);
        add_line(0, 0, 63, 63, 8'hff, 8'hff, 8'hff, 1'b0);
        add_line(63, 63, 0, 0, 8'h55, 8'haa, 8'h55, 1'b0);
        add_line(0, 63, 63, 0, 8'haa, 8'h55, 8'haa, 1'b0);
        add_line(63, 0, 0, 63, 8'h0f, 8'hf0, 8'h3c, 1'b0);
        add_line(0, 5, 63, 5, 8'h01, 8'h80, 8'hfe, 1'b0);
        add_line(63, 40, 0, 40, 8'h7f, 8'h00, 8'hff, 1'b0);
        add_line(7, 0, 7, 63, 8'h12, 8'h34, 8'h56, 1'b0);
        add_line(50, 63, 50, 0, 8'hc3, 8'h3c, 8'h99, 1'b0);
        add_line(0, 0, 2, 1, 8'h10, 8'h20, 8'h30, 1'b0);
        add_line(0, 1, 2, 0, 8'h40, 8'h50, 8'h60, 1'b0);
        add_line(0, 0, 1, 2, 8'h70, 8'h80, 8'h90, 1'b0);
        add_line(1, 0, 0, 2, 8'ha0, 8'hb0, 8'hc0, 1'b0);
        add_line(3, 4, 7, 6, 8'hd0, 8'he0, 8'hf0, 1'b0);
        add_line(20, 60, 25, 3, 8'h11, 8'h22, 8'h33, 1'b0);
        add_line(30, 63, 29, 0, 8'h44, 8'h55, 8'h66, 1'b0);
        add_line(5, 9, 1, 1, 8'h77, 8'h88, 8'h99, 1'b0);
        add_line(0, 0, 63, 1, 8'haa, 8'hbb, 8'hcc, 1'b0);
        add_line(63, 1, 0, 0, 8'hdd, 8'hee, 8'hff, 1'b0);
        add_line(12, 30, 44, 17, 8'h5a, 8'ha5, 8'h69, 1'b0);
        add_line(63, 63, 63, 63, 8'hff, 8'h00, 8'hff, 1'b0);
        add_line(0, 0, 0, 0, 8'h00, 8'hff, 8'h00, 1'b1);

        for (i = 0; i < RANDOM_LINES; i++) begin
            sx = $urandom_range(0, 63);
            sy = $urandom_range(0, 63);
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                ex = $urandom_range(0, 63);
                ey = $urandom_range(0, 63);
            end else if (kind < 7) begin
                ex = clamp_coord(sx + $urandom_range(0, 12) - 6);
                ey = clamp_coord(sy + $urandom_range(0, 12) - 6);
            end else if (kind == 7) begin
                ex = $urandom_range(0, 1) ? sx : $urandom_range(0, 63);
                ey = (ex == sx) ? $urandom_range(0, 63) : sy;
            end else if (kind == 8) begin
                ex = clamp_coord(sx + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, 20));
                ey = clamp_coord(sy + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, 20));
                ey = ($urandom_range(0, 1)) ? ey : clamp_coord(sy + (ex - sx) / 2);
            end else begin
                ex = sx;
                ey = sy;
            end
            add_line(sx, sy, ex, ey, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 49) == 0);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (line_cmds.size() != 0 || in_valid) begin
            @(posedge clk);
        end
        while (pending_pixels.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Drew %0d lines and checked %0d pixels in %0d cycles.",
                 lines_taken, pixels_seen, cycle_count);
        $display("Sink held off %0d times; sender paused for drain %0d times.",
                 sink_holds, drain_pauses);
        if (error_count == 0) begin
            $display("[line_rasterizer_top] OK");
        end else begin
            $display("[line_rasterizer_top] ERROR");
        end
        $finish;
    end

endmodule

@@ line_rasterizer_top.f @@
+incdir+hw/rtl
hw/rtl/lr_pkg.sv
hw/rtl/line_rasterizer_top.sv
tb/testbench.sv
